// ===== sv/avtr_pkg.sv =====
// Shared types and constants for the A/V timestamp rebaser.
`default_nettype none

package avtr_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BWD_LIMIT = 2'd1;

    localparam int unsigned TS_W    = 64;
    localparam int unsigned LIMIT_W = 32;

    // Limit values after reset, in milliseconds
    localparam logic [LIMIT_W-1:0] FWD_LIMIT_RESET = 32'd30000;
    localparam logic [LIMIT_W-1:0] BWD_LIMIT_RESET = 32'd300000;

    // Event codes reported with each result
    typedef enum logic [2:0] {
        EV_FIRST      = 3'd0,
        EV_NORMAL     = 3'd1,
        EV_FWD_REBASE = 3'd2,
        EV_BWD_REBASE = 3'd3,
        EV_BWD_HOLD   = 3'd4
    } event_kind_t;

    // Per-stream rebasing context
    typedef struct packed {
        logic            started;
        logic [TS_W-1:0] out_base;
        logic [TS_W-1:0] in_base;
        logic [TS_W-1:0] last_in;
        logic [TS_W-1:0] last_out;
    } stream_state_t;

endpackage

`default_nettype wire

// ===== sv/avtr_step.sv =====
// Rebasing decision and next stream context for one timestamp.
`default_nettype none

module avtr_step (
    input  wire avtr_pkg::stream_state_t        cur,
    input  wire                                 other_started,
    input  wire logic [avtr_pkg::TS_W-1:0]      other_out_base,
    input  wire logic [avtr_pkg::TS_W-1:0]      ts,
    input  wire logic [avtr_pkg::LIMIT_W-1:0]   fwd_limit,
    input  wire logic [avtr_pkg::LIMIT_W-1:0]   bwd_limit,
    output avtr_pkg::stream_state_t             nxt,
    output logic [avtr_pkg::TS_W-1:0]           res,
    output avtr_pkg::event_kind_t               ev
);

    logic                        is_fwd;
    logic [avtr_pkg::TS_W-1:0]   step_fwd;
    logic [avtr_pkg::TS_W-1:0]   step_bwd;
    logic [avtr_pkg::TS_W-1:0]   fwd_limit_ext;
    logic [avtr_pkg::TS_W-1:0]   bwd_limit_ext;
    logic [avtr_pkg::TS_W-1:0]   first_base;
    logic [avtr_pkg::TS_W-1:0]   normal_ts;

    // Classify the step and measure it as an unsigned magnitude
    assign is_fwd        = $signed(ts) >= $signed(cur.last_in);
    assign step_fwd      = ts - cur.last_in;
    assign step_bwd      = cur.last_in - ts;
    assign fwd_limit_ext = {{(avtr_pkg::TS_W-avtr_pkg::LIMIT_W){1'b0}}, fwd_limit};
    assign bwd_limit_ext = {{(avtr_pkg::TS_W-avtr_pkg::LIMIT_W){1'b0}}, bwd_limit};
    assign first_base    = other_started ? other_out_base : '0;
    assign normal_ts     = cur.out_base + (ts - cur.in_base);

    // Pick the event and update the stream context
    always_comb
    begin
        nxt         = cur;
        nxt.started = 1'b1;
        res         = cur.last_out;
        ev          = avtr_pkg::EV_BWD_HOLD;
        if (!cur.started)
        begin
            nxt.out_base = first_base;
            nxt.in_base  = ts;
            nxt.last_in  = ts;
            nxt.last_out = first_base;
            res          = first_base;
            ev           = avtr_pkg::EV_FIRST;
        end
        else
        begin
            nxt.last_in = ts;
            if (is_fwd)
            begin
                if (step_fwd < fwd_limit_ext)
                begin
                    nxt.last_out = normal_ts;
                    res          = normal_ts;
                    ev           = avtr_pkg::EV_NORMAL;
                end
                else
                begin
                    nxt.out_base = cur.last_out;
                    nxt.in_base  = ts;
                    ev           = avtr_pkg::EV_FWD_REBASE;
                end
            end
            else if (step_bwd > bwd_limit_ext)
            begin
                nxt.out_base = cur.last_out;
                nxt.in_base  = ts;
                ev           = avtr_pkg::EV_BWD_REBASE;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/av_timestamp_rebaser.sv =====
// Top level: per-stream decode timestamp rebaser for one video and one audio stream.
// An item passes the input register and then the result register, which drives out_valid and the result.
// Throughput: one item per cycle; the whole pipeline stalls only while a result waits under out_stall.
// Context for the next item of the same stream is updated in the result stage, so
// back-to-back items of one stream see each other's updates.
// Reset clears both started flags and output bases and reloads the jump limits to their defaults.
`default_nettype none

module av_timestamp_rebaser (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // configuration write channel
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [avtr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [avtr_pkg::LIMIT_W-1:0]   cfg_data,
    // input channel
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 stream_is_audio,
    input  wire logic signed [63:0]             in_timestamp,
    // result channel
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic signed [63:0]                  out_timestamp,
    output logic [2:0]                          event_kind
);

    logic                            advance;

    logic [avtr_pkg::LIMIT_W-1:0]    fwd_limit_reg;
    logic [avtr_pkg::LIMIT_W-1:0]    bwd_limit_reg;

    logic                            s1_valid_reg;
    logic                            s1_stream_reg;
    logic [avtr_pkg::TS_W-1:0]       s1_ts_reg;

    logic                            started_reg  [2];
    logic [avtr_pkg::TS_W-1:0]       out_base_reg [2];
    logic [avtr_pkg::TS_W-1:0]       in_base_reg  [2];
    logic [avtr_pkg::TS_W-1:0]       last_in_reg  [2];
    logic [avtr_pkg::TS_W-1:0]       last_out_reg [2];

    logic                            out_valid_reg;
    logic [avtr_pkg::TS_W-1:0]       out_ts_reg;
    avtr_pkg::event_kind_t           out_event_reg;

    logic                            other_sel;
    avtr_pkg::stream_state_t         cur_state;
    avtr_pkg::stream_state_t         state_next;
    logic [avtr_pkg::TS_W-1:0]       res_next;
    avtr_pkg::event_kind_t           event_next;

    // Move the pipeline unless a result is held under stall
    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_limit_reg <= avtr_pkg::FWD_LIMIT_RESET;
            bwd_limit_reg <= avtr_pkg::BWD_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                avtr_pkg::REG_FWD_LIMIT: fwd_limit_reg <= cfg_data;
                avtr_pkg::REG_BWD_LIMIT: bwd_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            s1_stream_reg <= stream_is_audio;
            s1_ts_reg     <= in_timestamp;
        end
    end

    // Gather the context of the selected stream
    assign other_sel          = ~s1_stream_reg;
    assign cur_state.started  = started_reg[s1_stream_reg];
    assign cur_state.out_base = out_base_reg[s1_stream_reg];
    assign cur_state.in_base  = in_base_reg[s1_stream_reg];
    assign cur_state.last_in  = last_in_reg[s1_stream_reg];
    assign cur_state.last_out = last_out_reg[s1_stream_reg];

    avtr_step u_step (
        .cur            (cur_state),
        .other_started  (started_reg[other_sel]),
        .other_out_base (out_base_reg[other_sel]),
        .ts             (s1_ts_reg),
        .fwd_limit      (fwd_limit_reg),
        .bwd_limit      (bwd_limit_reg),
        .nxt            (state_next),
        .res            (res_next),
        .ev             (event_next)
    );

    // Result stage: control and reset-defined context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            started_reg[0]  <= 1'b0;
            started_reg[1]  <= 1'b0;
            out_base_reg[0] <= '0;
            out_base_reg[1] <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                started_reg[s1_stream_reg]  <= state_next.started;
                out_base_reg[s1_stream_reg] <= state_next.out_base;
            end
        end
    end

    // Result stage: payload and context written before use
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            in_base_reg[s1_stream_reg]  <= state_next.in_base;
            last_in_reg[s1_stream_reg]  <= state_next.last_in;
            last_out_reg[s1_stream_reg] <= state_next.last_out;
            out_ts_reg                  <= res_next;
            out_event_reg               <= event_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_timestamp = out_ts_reg;
    assign event_kind    = out_event_reg;

    // Never take an item while a result is held under stall
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> in_stall)
        else $error("input transfer while result held");

    // A processed item always leaves its stream started
    a_started_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> started_reg[$past(s1_stream_reg)])
        else $error("stream not started after item");

    // Started flags never drop outside reset
    a_video_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(started_reg[0]))
        else $error("video started flag dropped");

    a_audio_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(started_reg[1]))
        else $error("audio started flag dropped");

    // A forward limit write lands in its register
    a_fwd_limit_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == avtr_pkg::REG_FWD_LIMIT)
        |=> fwd_limit_reg == $past(cfg_data))
        else $error("forward limit write lost");

endmodule

`default_nettype wire
